@@ rtl/zlhs_pkg.sv @@
// Shared types and constants for the ZIP local header scanner.
`timescale 1ns / 1ps
`default_nettype none
package zlhs_pkg;

    localparam logic [31:0] SIG_RESET = 32'h04034B50;

    // result kinds
    localparam logic [1:0] KIND_NAME_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY_NAME = 2'd1;
    localparam logic [1:0] KIND_SUMMARY    = 2'd2;

    // header byte offsets, counted from the byte after the signature
    localparam logic [4:0] NAME_LEN_LO_POS = 5'd22;
    localparam logic [4:0] NAME_LEN_HI_POS = 5'd23;
    localparam logic [4:0] HEADER_LAST_POS = 5'd25;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  name_byte;
        logic        last_of_name;
        logic [31:0] header_count;
        logic        no_archive;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/zlhs_in_if.sv @@
// Byte request channel into the scanner.
`timescale 1ns / 1ps
`default_nettype none
interface zlhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

@@ rtl/zlhs_out_if.sv @@
// Result channel out of the scanner.
`timescale 1ns / 1ps
`default_nettype none
interface zlhs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  name_byte;
    logic        last_of_name;
    logic [31:0] header_count;
    logic        no_archive;

    modport source (output valid, output result_kind, output name_byte,
                    output last_of_name, output header_count, output no_archive,
                    input ready);
    modport sink   (input valid, input result_kind, input name_byte,
                    input last_of_name, input header_count, input no_archive,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/zlhs_parser.sv @@
// Scan state: signature window, header skip, name emission, header count.
`timescale 1ns / 1ps
`default_nettype none
module zlhs_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_file,
    input  wire logic [31:0]     i_signature,
    output logic                 o_emit,
    output zlhs_pkg::t_result    o_result
);
    import zlhs_pkg::*;

    localparam logic [1:0] PH_SCAN   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_NAME   = 2'd2;

    logic [23:0] r_recent, n_recent;
    logic [1:0]  r_fill,   n_fill;
    logic [1:0]  r_phase,  n_phase;
    logic [4:0]  r_pos,    n_pos;
    logic [15:0] r_name,   n_name;
    logic [31:0] r_count,  n_count;

    always_comb begin
        n_recent = r_recent;
        n_fill   = r_fill;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_name   = r_name;
        n_count  = r_count;
        o_emit   = 1'b0;
        o_result.result_kind  = KIND_NAME_BYTE;
        o_result.name_byte    = 8'd0;
        o_result.last_of_name = 1'b0;
        o_result.header_count = r_count;
        o_result.no_archive   = 1'b0;
        if (i_accept) begin
            if (i_end_of_file) begin
                o_emit = 1'b1;
                o_result.result_kind = KIND_SUMMARY;
                o_result.no_archive  = (r_count == 32'd0);
                n_recent = 24'd0;
                n_fill   = 2'd0;
                n_phase  = PH_SCAN;
                n_pos    = 5'd0;
                n_name   = 16'd0;
                n_count  = 32'd0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos == NAME_LEN_LO_POS) begin
                            n_name = {8'd0, i_data_byte};
                        end else if (r_pos == NAME_LEN_HI_POS) begin
                            n_name = {i_data_byte, r_name[7:0]};
                        end
                        n_pos = r_pos + 5'd1;
                        if (r_pos == HEADER_LAST_POS) begin
                            n_pos = 5'd0;
                            if (n_name == 16'd0) begin
                                n_phase = PH_SCAN;
                                o_emit  = 1'b1;
                                o_result.result_kind  = KIND_EMPTY_NAME;
                                o_result.last_of_name = 1'b1;
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end
                    end
                    PH_NAME: begin
                        n_name = r_name - 16'd1;
                        o_emit = 1'b1;
                        o_result.result_kind  = KIND_NAME_BYTE;
                        o_result.name_byte    = i_data_byte;
                        o_result.last_of_name = (n_name == 16'd0);
                        if (n_name == 16'd0) begin
                            n_phase = PH_SCAN;
                        end
                    end
                    default: begin
                        // unused phase code falls back to scanning
                        n_phase = PH_SCAN;
                        if (r_fill == 2'd3 && {i_data_byte, r_recent} == i_signature) begin
                            if (r_count != 32'hFFFF_FFFF) begin
                                n_count = r_count + 32'd1;
                            end
                            n_phase  = PH_HEADER;
                            n_pos    = 5'd0;
                            n_name   = 16'd0;
                            n_recent = 24'd0;
                            n_fill   = 2'd0;
                        end else begin
                            n_recent = {i_data_byte, r_recent[23:8]};
                            if (r_fill != 2'd3) begin
                                n_fill = r_fill + 2'd1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= 24'd0;
            r_fill   <= 2'd0;
            r_phase  <= PH_SCAN;
            r_pos    <= 5'd0;
            r_name   <= 16'd0;
            r_count  <= 32'd0;
        end else begin
            r_recent <= n_recent;
            r_fill   <= n_fill;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_name   <= n_name;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/zip_local_header_scanner_core.sv @@
// Top level of the ZIP local header scanner: config register, parser, output register.
//
//  channel     dir   handshake      payload
//  i_in_ch     in    valid/ready    data_byte[8], end_of_file
//  o_out_ch    out   valid/ready    result_kind[2], name_byte[8], last_of_name,
//                                   header_count[32], no_archive
//  i_cfg_*     in    write enable   signature_word[32]
//
// One byte per cycle while ready is high; each request is handled in the cycle it is
// accepted and its result, if any, sits in the output register from the next cycle.
// Input ready is high whenever the output register is empty or being drained,
// so a stalled consumer holds off the producer after one pending result.
// Synchronous active-low reset clears scan state, count and the output valid
// flag, and loads the signature with 0x04034B50.
`timescale 1ns / 1ps
`default_nettype none
module zip_local_header_scanner_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    zlhs_in_if.sink          i_in_ch,
    zlhs_out_if.source       o_out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    import zlhs_pkg::*;

    logic [31:0] r_signature;
    logic        r_out_valid;
    t_result     r_out;
    logic        in_ready;
    logic        accept;
    logic        emit;
    t_result     result;

    assign in_ready = !r_out_valid || o_out_ch.ready;
    assign accept   = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    zlhs_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_in_ch.data_byte),
        .i_end_of_file (i_in_ch.end_of_file),
        .i_signature   (r_signature),
        .o_emit        (emit),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signature <= SIG_RESET;
        end else if (i_cfg_we) begin
            r_signature <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= result;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.result_kind  = r_out.result_kind;
    assign o_out_ch.name_byte    = r_out.name_byte;
    assign o_out_ch.last_of_name = r_out.last_of_name;
    assign o_out_ch.header_count = r_out.header_count;
    assign o_out_ch.no_archive   = r_out.no_archive;

`ifndef SYNTHESIS
    a_summary_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind == KIND_SUMMARY
        |-> r_out.no_archive == (r_out.header_count == 32'd0))
        else $error("summary no_archive disagrees with count");

    a_flag_only_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.no_archive |-> r_out.result_kind == KIND_SUMMARY)
        else $error("no_archive set outside a summary");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind == KIND_EMPTY_NAME
        |-> r_out.last_of_name && r_out.header_count != 32'd0)
        else $error("empty name result malformed");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out_ch.ready |-> !accept)
        else $error("request accepted while result stalled");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the ZIP local header scanner: header counts, names and summaries.
`timescale 1ns / 1ps
module tb_top;
    import zlhs_pkg::*;

    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_HEADER = 2'd1,
        PH_NAME   = 2'd2
    } t_scan_phase;

    localparam int HEADER_BYTES = 26;
    localparam int WHOLE_ENTRY  = 1 << 30;   // cut length meaning "send everything"

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    zlhs_in_if  in_ch ();
    zlhs_out_if out_ch ();

    zip_local_header_scanner_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predicted scanner state
    logic [31:0] exp_sig;
    logic [23:0] exp_window;
    logic [1:0]  exp_fill;
    t_scan_phase exp_phase;
    logic [4:0]  exp_hdr_pos;
    logic [15:0] exp_name_left;
    logic [31:0] exp_count;

    t_result expected_results[$];
    int      errors = 0;
    int      bytes_sent = 0;
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;

    task automatic clear_scan();
        exp_window    = '0;
        exp_fill      = '0;
        exp_phase     = PH_SCAN;
        exp_hdr_pos   = '0;
        exp_name_left = '0;
        exp_count     = '0;
    endtask

    function automatic t_result make_result(input logic [1:0] kind, input logic [7:0] b,
                                            input logic last, input logic no_arc);
        t_result r;
        r.result_kind  = kind;
        r.name_byte    = b;
        r.last_of_name = last;
        r.header_count = exp_count;
        r.no_archive   = no_arc;
        return r;
    endfunction

    task automatic predict_scan(input logic [7:0] b, input logic eof);
        if (eof) begin
            expected_results.push_back(
                make_result(KIND_SUMMARY, 8'h00, 1'b0, exp_count == 32'd0));
            clear_scan();
        end else begin
            case (exp_phase)
                PH_HEADER: begin
                    if (exp_hdr_pos == NAME_LEN_LO_POS)
                        exp_name_left = {8'h00, b};
                    else if (exp_hdr_pos == NAME_LEN_HI_POS)
                        exp_name_left[15:8] = b;
                    if (exp_hdr_pos == HEADER_LAST_POS) begin
                        exp_hdr_pos = '0;
                        if (exp_name_left == 16'd0) begin
                            exp_phase = PH_SCAN;
                            expected_results.push_back(
                                make_result(KIND_EMPTY_NAME, 8'h00, 1'b1, 1'b0));
                        end else begin
                            exp_phase = PH_NAME;
                        end
                    end else begin
                        exp_hdr_pos = exp_hdr_pos + 5'd1;
                    end
                end
                PH_NAME: begin
                    exp_name_left = exp_name_left - 16'd1;
                    if (exp_name_left == 16'd0)
                        exp_phase = PH_SCAN;
                    expected_results.push_back(
                        make_result(KIND_NAME_BYTE, b, exp_name_left == 16'd0, 1'b0));
                end
                default: begin
                    exp_phase = PH_SCAN;
                    if (exp_fill == 2'd3 && {b, exp_window} == exp_sig) begin
                        if (exp_count != 32'hFFFF_FFFF)
                            exp_count = exp_count + 32'd1;
                        exp_phase     = PH_HEADER;
                        exp_hdr_pos   = '0;
                        exp_name_left = '0;
                        exp_window    = '0;
                        exp_fill      = '0;
                    end else begin
                        exp_window = {b, exp_window[23:8]};
                        if (exp_fill != 2'd3)
                            exp_fill = exp_fill + 2'd1;
                    end
                end
            endcase
        end
    endtask

    // one request; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic [7:0] b, input logic eof);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_scan(b, eof);
        bytes_sent++;
    endtask

    task automatic send_eof();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // signature, 26 header bytes, name; stops after cut bytes past the signature
    task automatic send_header(input logic [15:0] name_len, input int cut);
        logic [31:0] sig;
        sig = exp_sig;
        for (int i = 0; i < 4; i++)
            send_item(sig[8*i +: 8], 1'b0);
        for (int i = 0; i < cut && i < HEADER_BYTES + int'(name_len); i++) begin
            if (i == int'(NAME_LEN_LO_POS))
                send_item(name_len[7:0], 1'b0);
            else if (i == int'(NAME_LEN_HI_POS))
                send_item(name_len[15:8], 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_signature(input logic [31:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        exp_sig = value;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // result consumer with random stalls
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = stalls_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with nothing expected, expected none, actual kind %0d",
                             $time, out_ch.result_kind);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(out_ch.result_kind));
                check_field("name_byte", 32'(want.name_byte), 32'(out_ch.name_byte));
                check_field("last_of_name", 32'(want.last_of_name), 32'(out_ch.last_of_name));
                check_field("header_count", want.header_count, out_ch.header_count);
                check_field("no_archive", 32'(want.no_archive), 32'(out_ch.no_archive));
            end
        end
    end

    task automatic test_empty_files();
        send_eof();
        send_eof();
    endtask

    task automatic test_one_entry();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_header(16'd2, WHOLE_ENTRY);
        send_eof();
    endtask

    // scanning restarts right after an empty name or a name with an empty window
    task automatic test_empty_name();
        send_header(16'd0, WHOLE_ENTRY);
        send_header(16'd1, WHOLE_ENTRY);
        send_header(16'd0, WHOLE_ENTRY);
        send_eof();
    endtask

    task automatic test_sliding_window();
        send_item(exp_sig[7:0], 1'b0);
        send_item(exp_sig[15:8], 1'b0);
        send_header(16'd1, WHOLE_ENTRY);
        send_eof();
    endtask

    // end of file inside a header, then inside a name
    task automatic test_truncated();
        send_header(16'd5, 10);
        send_eof();
        send_header(16'd4, HEADER_BYTES + 2);
        send_eof();
    endtask

    task automatic test_signature_extremes();
        write_signature(32'h0000_0000);
        repeat (3) send_item(8'h00, 1'b0);
        send_eof();
        send_header(16'd1, WHOLE_ENTRY);
        repeat (3) send_item(8'h00, 1'b0);
        send_eof();
        write_signature(32'hFFFF_FFFF);
        send_item(8'hFF, 1'b0);
        send_header(16'd0, WHOLE_ENTRY);
        send_eof();
        write_signature(SIG_RESET);
    endtask

    task automatic test_random_files();
        int          first;
        int          entries;
        int          pick;
        int          cut;
        logic [15:0] name_len;
        first = bytes_sent;
        while (bytes_sent - first < 120) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_signature(32'h0000_0000);
                    1:       write_signature(32'hFFFF_FFFF);
                    2, 3:    write_signature(SIG_RESET);
                    default: write_signature($urandom);
                endcase
            end
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            entries   = $urandom_range(0, 4);
            repeat (entries) begin
                repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_item(exp_sig[7:0], 1'b0);     // stray partial signature
                pick = $urandom_range(0, 29);
                if (pick == 0)
                    name_len = 16'(256 + $urandom_range(0, 40));
                else if (pick < 10)
                    name_len = 16'($urandom_range(6, 20));
                else
                    name_len = 16'($urandom_range(0, 5));
                cut = ($urandom_range(0, 9) == 0) ?
                      $urandom_range(0, HEADER_BYTES + name_len) : WHOLE_ENTRY;
                send_header(name_len, cut);
                if (cut != WHOLE_ENTRY)
                    break;
            end
            repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_eof();
        end
    endtask

    // name longer than one length byte, both sides at full rate
    task automatic test_long_name();
        write_signature(SIG_RESET);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_header(16'h0102, WHOLE_ENTRY);
        send_eof();
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'h00;
        in_ch.end_of_file = 1'b0;
        exp_sig           = SIG_RESET;
        clear_scan();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_files();
        test_one_entry();
        test_empty_name();
        test_sliding_window();
        test_truncated();
        test_signature_extremes();
        test_random_files();
        test_long_name();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/zlhs_pkg.sv
rtl/zlhs_in_if.sv
rtl/zlhs_out_if.sv
rtl/zlhs_parser.sv
rtl/zip_local_header_scanner_core.sv
tb/sv/tb_top.sv
